// ===== rtl/abec_pkg.sv =====
// ----------------------------------------------------------------------------
// abec_pkg
// Shared constants, types and codes of the adaptive bisection entropy coder.
// ----------------------------------------------------------------------------
package abec_pkg;

  localparam int ALPHABET_SIZE = 257;
  localparam int COUNT_BITS  = 16;
  localparam int MAX_BITS    = 17;
  localparam int SYM_BITS    = 9;
  localparam int DEPTH       = ALPHABET_SIZE + 1;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int NBIT_BITS   = $clog2(MAX_BITS + 1);
  localparam int CFG_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] ADDR_DIRECTION = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_LIMIT     = 3'd4;

  localparam logic [ADDR_BITS-1:0]  LAST_ADDR   = ADDR_BITS'(ALPHABET_SIZE);
  localparam logic [COUNT_BITS-1:0] RESET_TOTAL = COUNT_BITS'(ALPHABET_SIZE + 1);
  localparam logic [COUNT_BITS-1:0] RESET_LIMIT = 16'd16383;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic KIND_BIT   = 1'b0;
  localparam logic KIND_SYM   = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ENC_TOP, ST_ENC_BOT, ST_ENC_CAP, ST_ENC_BIT,
    ST_BUMP, ST_RESC, ST_INC, ST_DEC_SEARCH, ST_DEC_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_RD_TOP, OP_RD_BOT, OP_CAP_BOT, OP_BIT,
    OP_START_RESC, OP_START_INC, OP_RESC, OP_INC, OP_SEARCH, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic dir;
    logic sym_ok;
    logic out_free;
    logic enc_more;
    logic need_rescale;
    logic sweep_end;
    logic clear_end;
    logic srch_stop;
    logic srch_found;
  } status_t;

endpackage

// ===== rtl/abec_if.sv =====
// ----------------------------------------------------------------------------
// abec_in_if / abec_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface abec_in_if
  import abec_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SYM_BITS-1:0] symbol_in;
  logic                bit_in;
  modport source (output valid, symbol_in, bit_in, input ready);
  modport sink   (input valid, symbol_in, bit_in, output ready);
endinterface

interface abec_out_if
  import abec_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                kind;
  logic                bit_out;
  logic [SYM_BITS-1:0] symbol_out;
  logic                last;
  modport source (output valid, kind, bit_out, symbol_out, last, input ready);
  modport sink   (input valid, kind, bit_out, symbol_out, last, output ready);
endinterface

// ===== rtl/abec_ram.sv =====
// ----------------------------------------------------------------------------
// abec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 258
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/abec_ctrl.sv =====
// ----------------------------------------------------------------------------
// abec_ctrl
// Sequencer: steps one item through read, bisection, rescale and update.
// ----------------------------------------------------------------------------
module abec_ctrl
  import abec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (st.clear_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (st.dir != DIR_ENCODE) state_next = ST_DEC_SEARCH;
          else if (st.sym_ok) state_next = ST_ENC_TOP;
        end
      end
      ST_ENC_TOP: begin
        cmd.op = OP_RD_TOP;
        state_next = ST_ENC_BOT;
      end
      ST_ENC_BOT: begin
        cmd.op = OP_RD_BOT;
        state_next = ST_ENC_CAP;
      end
      ST_ENC_CAP: begin
        cmd.op = OP_CAP_BOT;
        state_next = ST_ENC_BIT;
      end
      ST_ENC_BIT: begin
        if (!st.enc_more) state_next = ST_BUMP;
        else if (st.out_free) cmd.op = OP_BIT;
      end
      ST_BUMP: begin
        if (st.need_rescale) begin
          cmd.op = OP_START_RESC;
          state_next = ST_RESC;
        end else begin
          cmd.op = OP_START_INC;
          state_next = ST_INC;
        end
      end
      ST_RESC: begin
        // The datapath chains into the increment sweep on the last entry.
        cmd.op = OP_RESC;
        if (st.sweep_end) state_next = ST_INC;
      end
      ST_INC: begin
        cmd.op = OP_INC;
        if (st.sweep_end) state_next = ST_IDLE;
      end
      ST_DEC_SEARCH: begin
        cmd.op = OP_SEARCH;
        if (st.srch_stop) state_next = st.srch_found ? ST_DEC_EMIT : ST_IDLE;
      end
      ST_DEC_EMIT: begin
        if (st.out_free) begin
          cmd.op = OP_EMIT;
          state_next = ST_BUMP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/abec_dp.sv =====
// ----------------------------------------------------------------------------
// abec_dp
// Datapath: coding interval, decode window, table sweeps and result register.
// ----------------------------------------------------------------------------
module abec_dp
  import abec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             st,
  input  logic                direction,
  input  count_t              limit,
  input  logic [SYM_BITS-1:0] symbol_in,
  input  logic                bit_in,
  output logic                ram_we,
  output addr_t               ram_waddr,
  output count_t              ram_wdata,
  output addr_t               ram_raddr,
  input  count_t              ram_rdata,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic                out_bit,
  output logic [SYM_BITS-1:0] out_symbol,
  output logic                out_last
);
  count_t total, dummy, dec_up, dec_lo;
  count_t hi, lo, top, bot;
  count_t prev_old, prev_new;
  logic [SYM_BITS-1:0] sym;
  logic [NBIT_BITS-1:0] nbits;
  addr_t idx, p_addr;
  logic iss, p_vld;

  count_t enc_half, nhi, nlo, dec_half;
  logic   up_sel, fit_now, fit_next;
  logic [COUNT_BITS:0] resc_cnt;
  count_t resc_new;
  logic   s_found, s_brk;

  always_comb begin
    enc_half = COUNT_BITS'(({1'b0, hi} + {1'b0, lo}) >> 1);
    up_sel   = ({1'b0, top} + {1'b0, bot}) >= {enc_half, 1'b0};
    nhi      = up_sel ? hi : enc_half;
    nlo      = up_sel ? enc_half : lo;
    fit_now  = (hi <= top) && (lo >= bot);
    fit_next = (nhi <= top) && (nlo >= bot);
    dec_half = COUNT_BITS'(({1'b0, dec_up} + {1'b0, dec_lo}) >> 1);
    // New count is the old one halved, rounding up.
    resc_cnt = ({1'b0, ram_rdata - prev_old} + 1'b1) >> 1;
    resc_new = COUNT_BITS'(resc_cnt) + prev_new;
    s_found  = (prev_old >= dec_up) && (ram_rdata <= dec_lo);
    s_brk    = ram_rdata < dec_up;
  end

  always_comb begin
    st.dir          = direction;
    st.sym_ok       = symbol_in < SYM_BITS'(ALPHABET_SIZE);
    st.out_free     = !out_valid || out_ready;
    st.enc_more     = !fit_now && (nbits < NBIT_BITS'(MAX_BITS));
    st.need_rescale = total >= limit;
    st.sweep_end    = p_vld && (p_addr == '0);
    st.clear_end    = idx == LAST_ADDR;
    st.srch_found   = p_vld && s_found;
    st.srch_stop    = p_vld && (s_found || s_brk || p_addr == LAST_ADDR);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_addr;
    ram_wdata = ram_rdata + 1'b1;
    ram_raddr = idx;
    case (cmd.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = RESET_TOTAL - COUNT_BITS'(idx);
      end
      OP_RD_TOP: ram_raddr = ADDR_BITS'(sym);
      OP_RD_BOT: ram_raddr = ADDR_BITS'(sym) + 1'b1;
      OP_RESC: begin
        ram_we    = p_vld;
        ram_wdata = resc_new;
      end
      OP_INC: ram_we = p_vld;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= RESET_TOTAL;
      dummy     <= COUNT_BITS'(1);
      dec_up    <= RESET_TOTAL;
      dec_lo    <= '0;
      idx       <= '0;
      iss       <= 1'b0;
      p_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_BIT || cmd.op == OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd.op)
        OP_CLEAR: idx <= idx + 1'b1;
        OP_ACCEPT: begin
          sym   <= symbol_in;
          hi    <= total;
          lo    <= '0;
          nbits <= '0;
          if (direction != DIR_ENCODE) begin
            if (bit_in) dec_lo <= dec_half;
            else dec_up <= dec_half;
            idx      <= ADDR_BITS'(1);
            iss      <= 1'b1;
            p_vld    <= 1'b0;
            prev_old <= total;
          end
        end
        OP_RD_BOT: top <= ram_rdata;
        OP_CAP_BOT: bot <= ram_rdata;
        OP_BIT: begin
          hi         <= nhi;
          lo         <= nlo;
          nbits      <= nbits + 1'b1;
          out_kind   <= KIND_BIT;
          out_bit    <= up_sel;
          out_symbol <= '0;
          out_last   <= fit_next || (nbits == NBIT_BITS'(MAX_BITS - 1));
        end
        OP_EMIT: begin
          out_kind   <= KIND_SYM;
          out_bit    <= 1'b0;
          out_symbol <= sym;
          out_last   <= 1'b1;
        end
        OP_START_RESC: begin
          idx      <= LAST_ADDR;
          iss      <= 1'b1;
          p_vld    <= 1'b0;
          prev_old <= '0;
          prev_new <= '0;
        end
        OP_START_INC: begin
          idx   <= ADDR_BITS'(sym);
          iss   <= 1'b1;
          p_vld <= 1'b0;
        end
        OP_RESC, OP_INC: begin
          p_vld  <= iss;
          p_addr <= idx;
          if (iss) begin
            if (idx == '0) iss <= 1'b0;
            else idx <= idx - 1'b1;
          end
          if (p_vld && cmd.op == OP_RESC) begin
            prev_old <= ram_rdata;
            prev_new <= resc_new;
            if (p_addr == LAST_ADDR) dummy <= resc_new;
            if (p_addr == '0) begin
              total <= resc_new;
              idx   <= ADDR_BITS'(sym);
              iss   <= 1'b1;
            end
          end
          if (p_vld && cmd.op == OP_INC && p_addr == '0) begin
            total  <= ram_rdata + 1'b1;
            dec_up <= ram_rdata + 1'b1;
            dec_lo <= '0;
          end
        end
        OP_SEARCH: begin
          p_vld  <= iss;
          p_addr <= idx;
          if (st.srch_stop) begin
            iss <= 1'b0;
          end else if (iss) begin
            if (idx == LAST_ADDR) iss <= 1'b0;
            else idx <= idx + 1'b1;
          end
          if (p_vld) begin
            prev_old <= ram_rdata;
            if (s_found) begin
              sym <= SYM_BITS'(p_addr - 1'b1);
            end else if (s_brk || p_addr == LAST_ADDR) begin
              // Window inside the dummy slot or too narrow: start over.
              if (dec_up <= dummy || {1'b0, dec_up} <= {1'b0, dec_lo} + 1'b1) begin
                dec_up <= total;
                dec_lo <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/adaptive_bisection_entropy_coder.sv =====
// Encode reads the symbol's two table entries, then emits its code bits one by
// one; decode scans table entries (up to 257) and updates the model if found.
// Update: each entry from the symbol down to the top is incremented in turn;
// when the total reaches the limit, all counts are first halved in one sweep.
// One item is in flight at a time. After reset a clearing pass loads the
// table before the first word is accepted; configuration is taken at once.
// ----------------------------------------------------------------------------
// adaptive_bisection_entropy_coder
// Adaptive bisection coder with a cumulative frequency table in RAM.
// ----------------------------------------------------------------------------
module adaptive_bisection_entropy_coder
  import abec_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  abec_in_if.sink                  din,
  abec_out_if.source               dout,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);
  logic    direction;
  count_t  limit;
  cmd_t    cmd;
  status_t st;
  logic    ram_we;
  addr_t   ram_waddr, ram_raddr;
  count_t  ram_wdata, ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      limit     <= RESET_LIMIT;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_DIRECTION: direction <= pwdata[0];
        ADDR_LIMIT:     limit <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_DIRECTION: prdata = APB_DATA_BITS'(direction);
      ADDR_LIMIT:     prdata = APB_DATA_BITS'(limit);
      default:        prdata = '0;
    endcase
  end

  abec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .st       (st),
    .cmd      (cmd)
  );

  abec_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .direction  (direction),
    .limit      (limit),
    .symbol_in  (din.symbol_in),
    .bit_in     (din.bit_in),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_ready  (dout.ready),
    .out_valid  (dout.valid),
    .out_kind   (dout.kind),
    .out_bit    (dout.bit_out),
    .out_symbol (dout.symbol_out),
    .out_last   (dout.last)
  );

  abec_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule
